>>> rtl/rth_pkg.sv
// Shared types and constants for the RGB to HSL converter.
// No dependencies; imported by every module under rtl/.
package rth_pkg;

    // Channel width and quotient width of each divider row
    localparam int CH_W    = 8;
    localparam int Q_W     = 15;
    localparam int NUM_W   = CH_W + Q_W;   // numerator width: 23 bits
    localparam int POS_W   = 11;           // hue position, 0 .. 6*255 - 1
    localparam int SAT_W   = 13;
    localparam int SUM_W   = 9;

    // Fixed-point scale factors
    localparam logic [11:0] HUE_SECTOR = 12'd3840;   // 60 degrees in 1/64 degree
    localparam int          SAT_SHIFT  = 12;         // saturation scale 4096

    // Input beat
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix_in;

    // Result beat
    typedef struct packed {
        logic [Q_W-1:0]   hue_q;
        logic [SAT_W-1:0] sat_q;
        logic [SUM_W-1:0] light_sum;
    } t_pix_out;

    // One restoring-division lane: partial remainder, numerator bits still to
    // be consumed with quotient bits filling in from the bottom, and divisor
    typedef struct packed {
        logic [CH_W-1:0] rem;
        logic [Q_W-1:0]  nq;
        logic [CH_W-1:0] den;
    } t_div;

    // Everything handed from one cell to the next
    typedef struct packed {
        logic             valid;
        logic             grey;
        logic [SUM_W-1:0] light_sum;
        t_div             hue;
        t_div             sat;
    } t_stage;

endpackage

>>> rtl/rth_front.sv
// Front stage: max/min, hue position, numerators and divisors.
// Depends on rth_pkg.
module rth_front
    import rth_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_pix_in i_pix,
    output t_stage  o_stage
);

    logic [CH_W-1:0]  mx, mn, delta, sat_den;
    logic [SUM_W-1:0] sum;
    logic [POS_W-1:0] pos, r_e, g_e, b_e, d_e;
    logic [NUM_W-1:0] hue_num;
    t_stage           n_stage, r_stage;

    // True maximum and minimum
    always_comb begin
        mx = i_pix.red;
        if (i_pix.green > mx) mx = i_pix.green;
        if (i_pix.blue > mx)  mx = i_pix.blue;
        mn = i_pix.red;
        if (i_pix.green < mn) mn = i_pix.green;
        if (i_pix.blue < mn)  mn = i_pix.blue;
    end

    assign delta = mx - mn;
    assign sum   = {1'b0, mx} + {1'b0, mn};
    assign r_e   = POS_W'(i_pix.red);
    assign g_e   = POS_W'(i_pix.green);
    assign b_e   = POS_W'(i_pix.blue);
    assign d_e   = POS_W'(delta);

    // Hue position k*delta + diff, always in [0, 6*delta); red wins ties, then green
    always_comb begin
        if (i_pix.red == mx) begin
            if (i_pix.green >= i_pix.blue) pos = g_e - b_e;
            else                           pos = POS_W'(6) * d_e - (b_e - g_e);
        end else if (i_pix.green == mx) begin
            pos = (d_e << 1) + b_e - r_e;
        end else begin
            pos = (d_e << 2) + r_e - g_e;
        end
    end

    assign hue_num = NUM_W'(HUE_SECTOR) * NUM_W'(pos);

    // Dark rule up to and including the midpoint, light rule above it
    assign sat_den = (sum <= SUM_W'(255)) ? sum[CH_W-1:0]
                                          : CH_W'(SUM_W'(510) - sum);

    // Load both division lanes; top numerator bits seed the remainder
    always_comb begin
        n_stage           = r_stage;
        n_stage.valid     = i_valid;
        n_stage.grey      = (delta == '0);
        n_stage.light_sum = sum;
        n_stage.hue.rem   = hue_num[NUM_W-1:Q_W];
        n_stage.hue.nq    = hue_num[Q_W-1:0];
        n_stage.hue.den   = delta;
        n_stage.sat.rem   = CH_W'(delta >> (Q_W - SAT_SHIFT));
        n_stage.sat.nq    = Q_W'({delta, SAT_SHIFT'(0)});
        n_stage.sat.den   = sat_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.grey      <= n_stage.grey;
        r_stage.light_sum <= n_stage.light_sum;
        r_stage.hue       <= n_stage.hue;
        r_stage.sat       <= n_stage.sat;
    end

    assign o_stage = r_stage;

endmodule

>>> rtl/rth_cell.sv
// One cell of the divider chain: one quotient bit for hue and for saturation.
// Depends on rth_pkg.
module rth_cell
    import rth_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    output t_stage o_stage
);

    t_stage n_stage, r_stage;

    // Restoring step: shift in the next numerator bit, subtract if it fits
    function automatic t_div div_step(input t_div d);
        logic [CH_W:0] t;
        logic          q;
        t_div          o;
        t = {d.rem, d.nq[Q_W-1]};
        q = (t >= {1'b0, d.den});
        o.den = d.den;
        o.rem = q ? CH_W'(t - {1'b0, d.den}) : t[CH_W-1:0];
        o.nq  = {d.nq[Q_W-2:0], q};
        return o;
    endfunction

    always_comb begin
        n_stage     = i_stage;
        n_stage.hue = div_step(i_stage.hue);
        n_stage.sat = div_step(i_stage.sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.grey      <= n_stage.grey;
        r_stage.light_sum <= n_stage.light_sum;
        r_stage.hue       <= n_stage.hue;
        r_stage.sat       <= n_stage.sat;
    end

    assign o_stage = r_stage;

endmodule

>>> rtl/rgb_to_hsl.sv
// RGB to HSL converter, top level: front stage, divider cell chain, output register.
// Depends on rth_pkg, rth_front and rth_cell.
//
// Takes one 8-bit RGB pixel on every clock in which start is high; busy is
// always low, so a new pixel may be offered each cycle. Each pixel yields one
// result, shown for exactly one cycle with o_valid high, once it has passed
// one front stage, fifteen divider cells (one quotient bit each for hue and
// saturation) and one output register. The receiver cannot hold results
// off. hue_q is hue in 1/64 degree (0 for grey), sat_q is saturation times
// 4096 (0 for grey), light_sum is max plus min.
module rgb_to_hsl
    import rth_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_pix_in  i_pix,
    output logic     busy,
    output logic     o_valid,
    output t_pix_out o_res
);

    t_stage   chain [Q_W+1];
    t_pix_out n_res, r_res;
    logic     r_valid;

    assign busy = 1'b0;

    rth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_pix   (i_pix),
        .o_stage (chain[0])
    );

    // Divider chain: one cell per quotient bit
    for (genvar i = 0; i < Q_W; i++) begin : g_cell
        rth_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (chain[i]),
            .o_stage (chain[i+1])
        );
    end

    // Grey pixels force hue and saturation to zero
    always_comb begin
        n_res.light_sum = chain[Q_W].light_sum;
        if (chain[Q_W].grey) begin
            n_res.hue_q = '0;
            n_res.sat_q = '0;
        end else begin
            n_res.hue_q = chain[Q_W].hue.nq;
            n_res.sat_q = chain[Q_W].sat.nq[SAT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= chain[Q_W].valid;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> verif/hsl_checker.sv
// Scoreboard for the RGB to HSL converter: predicts each result from the accepted pixel.
// Depends on rth_pkg; watches the input and result channels of rgb_to_hsl.
// Reports a running failure count and the number of results still awaited.
module hsl_checker
    import rth_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_pix_in  i_pix,
    input  logic     i_valid,
    input  t_pix_out i_res,
    output int       o_fail_count,
    output int       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HUE_PER_SECTOR = 3840;   // 60 degrees in 1/64 degree
    localparam int unsigned SAT_FULL       = 4096;
    localparam int unsigned SUM_MID        = 255;
    localparam int          MAX_REPORTS    = 10;

    t_pix_out hsl_due[$];
    int       fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Expected HSL of one pixel, exact integer arithmetic
    function automatic t_pix_out hsl_of(t_pix_in p);
        logic [CH_W-1:0]  r, g, b, mx, mn;
        logic [SUM_W-1:0] sum;
        int unsigned      delta, pos, den;
        t_pix_out         res;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = 32'(mx - mn);
        sum   = {1'b0, mx} + {1'b0, mn};
        res   = '0;
        res.light_sum = sum;
        if (delta != 0) begin
            // sector rule; red wins ties over green, green over blue
            if (r == mx) begin
                if (g >= b) pos = 32'(g - b);
                else        pos = 6 * delta - 32'(b - g);
            end else if (g == mx) begin
                pos = 2 * delta + 32'(b) - 32'(r);
            end else begin
                pos = 4 * delta + 32'(r) - 32'(g);
            end
            res.hue_q = Q_W'((HUE_PER_SECTOR * pos) / delta);
            // midpoint sum takes the dark rule
            den = (sum <= SUM_MID) ? 32'(sum) : (2 * SUM_MID - 32'(sum));
            res.sat_q = SAT_W'((SAT_FULL * delta) / den);
        end
        return res;
    endfunction

    task automatic report_fail(string what, t_pix_out want, t_pix_out got);
        fails++;
        if (fails <= MAX_REPORTS)
            $display("[%0t] %s: expected hue %0d sat %0d sum %0d, got hue %0d sat %0d sum %0d",
                     $realtime, what, want.hue_q, want.sat_q, want.light_sum,
                     got.hue_q, got.sat_q, got.light_sum);
    endtask

    // Match result beats against the oldest prediction, then log new input beats
    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n) begin
            if (i_valid) begin
                if (hsl_due.size() == 0) begin
                    report_fail("unexpected result beat", '0, i_res);
                end else begin
                    want = hsl_due.pop_front();
                    if (i_res.hue_q !== want.hue_q || i_res.sat_q !== want.sat_q ||
                        i_res.light_sum !== want.light_sum)
                        report_fail("result mismatch", want, i_res);
                end
            end
            if (i_start && !i_busy)
                hsl_due.push_back(hsl_of(i_pix));
        end
        o_fail_count <= fails;
        o_pending    <= hsl_due.size();
    end

endmodule

>>> verif/testbench.sv
// Top of the RGB to HSL testbench: clock, reset, pixel stimulus and the verdict.
// Depends on rth_pkg, rgb_to_hsl and hsl_checker.
module testbench
    import rth_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM   = 800;
    localparam int DRAIN_MAX  = 2000;
    localparam int SETTLE     = 40;    // comfortably beyond the time a pixel spends in the pipeline

    // Directed pixels: extremes, grey, ties, hue wrap, saturation midpoint
    localparam t_pix_in DIRECTED [N_DIRECTED] = '{
        {8'd0,   8'd0,   8'd0},     // black
        {8'd255, 8'd255, 8'd255},   // white
        {8'd128, 8'd128, 8'd128},   // mid grey
        {8'd255, 8'd0,   8'd0},
        {8'd0,   8'd255, 8'd0},
        {8'd0,   8'd0,   8'd255},
        {8'd255, 8'd255, 8'd0},     // red and green tie
        {8'd0,   8'd255, 8'd255},   // green and blue tie
        {8'd255, 8'd0,   8'd255},   // red and blue tie, wraps
        {8'd255, 8'd0,   8'd1},     // just under 360 degrees
        {8'd255, 8'd1,   8'd0},
        {8'd1,   8'd0,   8'd0},
        {8'd0,   8'd1,   8'd0},
        {8'd0,   8'd0,   8'd1},
        {8'd255, 8'd128, 8'd0},     // sum at the midpoint
        {8'd200, 8'd55,  8'd100},   // sum at the midpoint
        {8'd200, 8'd56,  8'd100},   // just past the midpoint
        {8'd254, 8'd255, 8'd255},
        {8'd1,   8'd0,   8'd1},
        {8'd100, 8'd50,  8'd25},
        {8'd10,  8'd200, 8'd30},
        {8'd30,  8'd40,  8'd220},
        {8'd255, 8'd254, 8'd0},
        {8'd0,   8'd254, 8'd255}
    };

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_pix_in  i_pix   = '0;
    logic     busy;
    logic     o_valid;
    t_pix_out o_res;
    int       fail_count;
    int       pending;

    rgb_to_hsl uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_pix   (i_pix),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    hsl_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_pix        (i_pix),
        .i_valid      (o_valid),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Random pixel, biased towards grey, ties, extremes and the midpoint
    function automatic t_pix_in random_pix();
        logic [7:0] v [3];
        logic [7:0] tmp;
        int         j;
        case ($urandom_range(0, 9))
            5: begin
                v[0] = 8'($urandom_range(0, 255));
                v[1] = v[0];
                v[2] = v[0];
            end
            6: begin
                // two channels share the maximum
                v[0] = 8'($urandom_range(1, 255));
                v[1] = v[0];
                v[2] = 8'($urandom_range(0, v[0] - 1));
            end
            7: begin
                v[0] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                v[1] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                v[2] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            8: begin
                // two channels share the minimum
                v[0] = 8'($urandom_range(0, 254));
                v[1] = v[0];
                v[2] = 8'($urandom_range(v[0] + 1, 255));
            end
            9: begin
                // max plus min lands on the midpoint or one past it
                v[0] = 8'($urandom_range(128, 255));
                v[1] = 8'(255 - v[0] + $urandom_range(0, 1));
                v[2] = 8'($urandom_range(v[1], v[0]));
            end
            default: begin
                v[0] = 8'($urandom_range(0, 255));
                v[1] = 8'($urandom_range(0, 255));
                v[2] = 8'($urandom_range(0, 255));
            end
        endcase
        // shuffle channel order
        for (int k = 2; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp  = v[k];
            v[k] = v[j];
            v[j] = tmp;
        end
        return {v[0], v[1], v[2]};
    endfunction

    // Offer one beat and hold it until taken
    task automatic send_pix(t_pix_in p);
        i_pix <= p;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Stimulus in bursts, then drain and verdict
    initial begin
        int n_sent;
        int burst;
        int gap;
        int waited;
        int total_fails;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        n_sent = 0;
        while (n_sent < N_DIRECTED + N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n_sent < N_DIRECTED + N_RANDOM; k++) begin
                send_pix(n_sent < N_DIRECTED ? DIRECTED[n_sent] : random_pix());
                n_sent++;
            end
            // a zero gap keeps start high straight into the next burst
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);

        // predictions never matched count as failures
        total_fails = fail_count + pending;
        if (total_fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
